// ===== rtl/core/dsc_pkg.sv =====
// Package for the date span calculator: widths, constants and calendar tables.
// Used by dsc_day_number and date_span_calculator; depends on nothing else.
`default_nettype none

package dsc_pkg;

    localparam int unsigned YEAR_MAX_DEF = 9999;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int MIN_W   = 11;
    localparam int NUM_W   = 23;  // day number of a date
    localparam int DDIF_W  = 22;
    localparam int MDIF_W  = 33;
    localparam int Q100_W  = 8;   // year / 100
    localparam int PROD_W  = 34;  // day span * minutes per day

    localparam int IN_W  = 72;
    localparam int OUT_W = 64;

    // year / 100 as (year * RECIP100) >> RECIP_SHIFT, exact for 14-bit years
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 15;
    localparam int RPROD_W     = YEAR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);

    localparam logic [YEAR_W-1:0] CENTURY      = YEAR_W'(100);
    localparam logic [NUM_W-1:0]  DAYS_IN_YEAR = NUM_W'(365);
    localparam logic [MIN_W-1:0]  MIN_PER_DAY  = MIN_W'(1440);

    localparam logic [DAY_W-1:0] LEN_FEB      = DAY_W'(28);
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = DAY_W'(29);
    localparam logic [DAY_W-1:0] LEN_SHORT    = DAY_W'(30);
    localparam logic [DAY_W-1:0] LEN_LONG     = DAY_W'(31);

    localparam logic [MONTH_W-1:0] M_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] M_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] M_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] M_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] M_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] M_DEC = MONTH_W'(12);

    localparam logic [DDIF_W-1:0] DDIF_SAT = '1;
    localparam logic [MDIF_W-1:0] MDIF_SAT = '1;

    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

    // days before the month; month zero counts as January, above twelve as a full year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            4'd12:      v = 9'd334;
            default:    v = 9'd365;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] v;
        unique case (m) inside
            M_FEB:                      v = leap ? LEN_FEB_LEAP : LEN_FEB;
            M_APR, M_JUN, M_SEP, M_NOV: v = LEN_SHORT;
            default:                    v = LEN_LONG;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/date_span_calculator.sv =====
// Top level of the date span calculator: stream ports, span and minute pipeline.
// Depends on dsc_pkg and dsc_day_number (one instance per date).
//
// Each input item carries two Gregorian dates with a time of day in minutes; each
// result gives the day span, the elapsed minutes and a validity flag per date.
// The datapath is a five-stage pipeline (two day-number stages, span compare,
// span x 1440 multiply, minute sum and saturation). m_axis_tvalid is the valid flag of
// the last of the five register stages (r_v5), held until taken, and one item is taken
// every cycle while the output side keeps up; each stage holds its item under
// backpressure, so a stall only stops the stages behind a full one. Years above
// YEAR_MAX are clamped for day counting. There is no state between items and no
// clearing after reset.
`default_nettype none

module date_span_calculator #(
    parameter int unsigned YEAR_MAX = dsc_pkg::YEAR_MAX_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_day, first_month, first_year, first_minute,
    // second_day, second_month, second_year, second_minute, zero pad
    input  wire logic [dsc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // day_difference, minute_difference, first_valid, second_valid, zero pad
    output logic      [dsc_pkg::OUT_W-1:0] m_axis_tdata
);

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic ld1, ld2, ld3, ld4, ld5;
    dsc_pkg::t_stage_en stage_en;

    assign ld5 = !r_v5 || m_axis_tready;
    assign ld4 = !r_v4 || ld5;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign s_axis_tready = ld1;
    assign stage_en.s1 = ld1;
    assign stage_en.s2 = ld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= s_axis_tvalid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
        end
    end

    // input unpack
    logic [dsc_pkg::MIN_W-1:0] t1_in, t2_in;
    logic [dsc_pkg::MIN_W-1:0] r_t1_a, r_t2_a, r_t1_b, r_t2_b;

    assign t1_in = s_axis_tdata[33:23];
    assign t2_in = s_axis_tdata[67:57];

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_t1_a <= t1_in;
            r_t2_a <= t2_in;
        end
        if (ld2) begin
            r_t1_b <= r_t1_a;
            r_t2_b <= r_t2_a;
        end
    end

    // stages 1-2: day numbers
    logic [dsc_pkg::NUM_W-1:0] num1, num2;
    logic                      val1, val2;

    dsc_day_number #(.YEAR_MAX(YEAR_MAX)) u_first (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_day    (s_axis_tdata[4:0]),
        .i_month  (s_axis_tdata[8:5]),
        .i_year   (s_axis_tdata[22:9]),
        .o_number (num1),
        .o_valid  (val1)
    );

    dsc_day_number #(.YEAR_MAX(YEAR_MAX)) u_second (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_day    (s_axis_tdata[38:34]),
        .i_month  (s_axis_tdata[42:39]),
        .i_year   (s_axis_tdata[56:43]),
        .o_number (num2),
        .o_valid  (val2)
    );

    // stage 3: span and order
    logic                      n_same;
    logic [dsc_pkg::NUM_W-1:0] n_span;
    logic [dsc_pkg::MIN_W-1:0] n_early, n_late, n_tabs;

    logic                      r_same3, r_val1_3, r_val2_3;
    logic [dsc_pkg::NUM_W-1:0] r_span;
    logic [dsc_pkg::MIN_W-1:0] r_early3, r_late3, r_tabs3;

    always_comb begin
        n_same = (num1 == num2);
        if (num1 < num2) begin
            n_span  = num2 - num1;
            n_early = r_t1_b;
            n_late  = r_t2_b;
        end else begin
            n_span  = num1 - num2;
            n_early = r_t2_b;
            n_late  = r_t1_b;
        end
        n_tabs = (r_t1_b > r_t2_b) ? r_t1_b - r_t2_b : r_t2_b - r_t1_b;
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_same3  <= n_same;
            r_span   <= n_span;
            r_early3 <= n_early;
            r_late3  <= n_late;
            r_tabs3  <= n_tabs;
            r_val1_3 <= val1;
            r_val2_3 <= val2;
        end
    end

    // stage 4: span * 1440, day saturation
    logic [dsc_pkg::PROD_W-1:0] n_prod;
    logic [dsc_pkg::DDIF_W-1:0] n_dsat;

    logic                       r_same4, r_val1_4, r_val2_4;
    logic [dsc_pkg::PROD_W-1:0] r_prod;
    logic [dsc_pkg::DDIF_W-1:0] r_dsat;
    logic [dsc_pkg::MIN_W-1:0]  r_early4, r_late4, r_tabs4;

    always_comb begin
        n_prod = dsc_pkg::PROD_W'(r_span) * dsc_pkg::PROD_W'(dsc_pkg::MIN_PER_DAY);
        n_dsat = (r_span > dsc_pkg::NUM_W'(dsc_pkg::DDIF_SAT))
               ? dsc_pkg::DDIF_SAT : r_span[dsc_pkg::DDIF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_same4  <= r_same3;
            r_prod   <= n_prod;
            r_dsat   <= n_dsat;
            r_early4 <= r_early3;
            r_late4  <= r_late3;
            r_tabs4  <= r_tabs3;
            r_val1_4 <= r_val1_3;
            r_val2_4 <= r_val2_3;
        end
    end

    // stage 5: minutes, saturation, output register
    logic [dsc_pkg::PROD_W:0]   base, mraw;
    logic [dsc_pkg::MDIF_W-1:0] n_mins;
    logic [dsc_pkg::OUT_W-1:0]  n_out;
    logic [dsc_pkg::OUT_W-1:0]  r_out;

    always_comb begin
        base = (dsc_pkg::PROD_W+1)'(r_prod) + (dsc_pkg::PROD_W+1)'(r_late4);
        mraw = (base > (dsc_pkg::PROD_W+1)'(r_early4))
             ? base - (dsc_pkg::PROD_W+1)'(r_early4) : '0;
        if (r_same4) begin
            n_mins = dsc_pkg::MDIF_W'(r_tabs4);
        end else if (mraw > (dsc_pkg::PROD_W+1)'(dsc_pkg::MDIF_SAT)) begin
            n_mins = dsc_pkg::MDIF_SAT;
        end else begin
            n_mins = mraw[dsc_pkg::MDIF_W-1:0];
        end
        n_out = {7'd0, r_val2_4, r_val1_4, n_mins, r_dsat};
    end

    always_ff @(posedge i_clk) begin
        if (ld5) r_out <= n_out;
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = r_out;

    // checks
    a_same_day_minutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[21:0] == 22'd0)) |-> (m_axis_tdata[54:33] == 22'd0))
        else $error("zero day span with minute span of 2048 or more");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_v1 && !r_v2 && !r_v3 && !r_v4))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== rtl/core/dsc_day_number.sv =====
// Two-stage date to day-number converter with month/day validity check.
// Depends on dsc_pkg; stage enables come from the top level's pipeline control.
`default_nettype none

module dsc_day_number #(
    parameter int unsigned YEAR_MAX = dsc_pkg::YEAR_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire dsc_pkg::t_stage_en           i_en,
    input  wire logic [dsc_pkg::DAY_W-1:0]    i_day,
    input  wire logic [dsc_pkg::MONTH_W-1:0]  i_month,
    input  wire logic [dsc_pkg::YEAR_W-1:0]   i_year,
    output logic      [dsc_pkg::NUM_W-1:0]    o_number,
    output logic                              o_valid
);

    localparam logic [16:0] YMAX = 17'(YEAR_MAX);

    // stage 1
    logic [dsc_pkg::YEAR_W-1:0]  n_yy;
    logic [dsc_pkg::Q100_W-1:0]  n_qyy, n_qy;
    logic [dsc_pkg::RPROD_W-1:0] rp_yy, rp_y;
    logic [dsc_pkg::NUM_W-1:0]   n_yy365;

    logic [dsc_pkg::DAY_W-1:0]   r_day;
    logic [dsc_pkg::MONTH_W-1:0] r_month;
    logic [dsc_pkg::YEAR_W-1:0]  r_yy, r_y;
    logic [dsc_pkg::Q100_W-1:0]  r_qyy, r_qy;
    logic [dsc_pkg::NUM_W-1:0]   r_yy365;

    always_comb begin
        n_yy    = (17'(i_year) > YMAX) ? YMAX[dsc_pkg::YEAR_W-1:0] : i_year;
        rp_yy   = dsc_pkg::RPROD_W'(n_yy) * dsc_pkg::RPROD_W'(dsc_pkg::RECIP100);
        rp_y    = dsc_pkg::RPROD_W'(i_year) * dsc_pkg::RPROD_W'(dsc_pkg::RECIP100);
        n_qyy   = dsc_pkg::Q100_W'(rp_yy >> dsc_pkg::RECIP_SHIFT);
        n_qy    = dsc_pkg::Q100_W'(rp_y >> dsc_pkg::RECIP_SHIFT);
        n_yy365 = dsc_pkg::NUM_W'(n_yy) * dsc_pkg::DAYS_IN_YEAR;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_day   <= i_day;
            r_month <= i_month;
            r_yy    <= n_yy;
            r_y     <= i_year;
            r_qyy   <= n_qyy;
            r_qy    <= n_qy;
            r_yy365 <= n_yy365;
        end
    end

    // stage 2
    logic [dsc_pkg::YEAR_W-1:0] rem_yy, rem_y;
    logic                       leap_yy, leap_y;
    logic [dsc_pkg::NUM_W:0]    sum;
    logic [dsc_pkg::NUM_W-1:0]  n_number;
    logic                       n_valid;
    logic [dsc_pkg::NUM_W-1:0]  r_number;
    logic                       r_valid;

    always_comb begin
        rem_yy  = r_yy - dsc_pkg::YEAR_W'(dsc_pkg::YEAR_W'(r_qyy) * dsc_pkg::CENTURY);
        rem_y   = r_y  - dsc_pkg::YEAR_W'(dsc_pkg::YEAR_W'(r_qy)  * dsc_pkg::CENTURY);
        leap_yy = (r_yy[1:0] == 2'd0) && ((rem_yy != '0) || (r_qyy[1:0] == 2'd0));
        leap_y  = (r_y[1:0]  == 2'd0) && ((rem_y  != '0) || (r_qy[1:0]  == 2'd0));
        // days before the year: yy*365 + ceil(yy/4) - ceil(yy/100) + ceil(yy/400)
        sum = (dsc_pkg::NUM_W+1)'(r_yy365)
            + (dsc_pkg::NUM_W+1)'(r_yy >> 2)
            + (dsc_pkg::NUM_W+1)'(r_yy[1:0] != 2'd0)
            - (dsc_pkg::NUM_W+1)'(r_qyy)
            - (dsc_pkg::NUM_W+1)'(rem_yy != '0)
            + (dsc_pkg::NUM_W+1)'(r_qyy >> 2)
            + (dsc_pkg::NUM_W+1)'((rem_yy != '0) || (r_qyy[1:0] != 2'd0))
            + (dsc_pkg::NUM_W+1)'(dsc_pkg::month_start(r_month))
            + (dsc_pkg::NUM_W+1)'((r_month > dsc_pkg::M_FEB) && leap_yy)
            + (dsc_pkg::NUM_W+1)'(r_day);
        n_number = sum[dsc_pkg::NUM_W-1:0];
        n_valid  = (r_month >= dsc_pkg::M_JAN) && (r_month <= dsc_pkg::M_DEC)
                && (r_day != '0) && (r_day <= dsc_pkg::month_len(r_month, leap_y));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_number <= n_number;
            r_valid  <= n_valid;
        end
    end

    assign o_number = r_number;
    assign o_valid  = r_valid;

endmodule

`default_nettype wire
